// File: hw/rtl/msp_v1_frame_receiver_assert.svh
// Assertion macros used by the receiver top level.
`ifndef MSP_V1_FRAME_RECEIVER_ASSERT_SVH
`define MSP_V1_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define MSPFR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define MSPFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/mspfr_pkg.sv
package mspfr_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned OUT_DATA_W = 40;

    typedef logic [BYTE_W-1:0] t_byte;

    // framing characters
    localparam t_byte START_CHAR = 8'h24;
    localparam t_byte MARK_CHAR  = 8'h4D;

    typedef struct packed {
        logic  kind;
        t_byte payload_byte;
        t_byte message_id;
        t_byte direction;
        t_byte payload_length;
        logic  checksum_ok;
        logic  last;
    } t_result;

endpackage

// File: hw/rtl/msp_v1_frame_receiver.sv
// MultiWii serial protocol v1 frame receiver.
// Slave stream: one received serial byte per item on s_axis_tdata.
// Master stream: one item per payload byte and one end-of-frame item per frame.
//   tuser is the kind (0 payload byte, 1 end of frame), tlast marks end of frame,
//   tdata carries payload byte, id, direction, length and the checksum verdict.
// A frame is '$', 'M', direction, length, id, payload bytes, checksum byte.
// Any byte other than 'M' after '$' restarts the hunt; a second '$' there is not
// taken as a new start, so the hunt resumes with the byte after it.
// The verdict compares the checksum with the XOR of length, id and payload.
// A byte is accepted into the input register and its result is loaded into the
// output register. Throughput: one byte per cycle while the sink keeps tready high; the input
// register, the frame state update and the output register each handle one item per cycle.
// Reset (synchronous, active low) returns to hunting and empties both stages.
// When the sink holds tready low, the output stage holds its item and catches
// one more in a skid entry; the input register takes one further byte and
// s_axis_tready then stays low until the skid entry drains.
module msp_v1_frame_receiver (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // [7:0] rx_byte
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [7:0] payload_byte, [15:8] message_id, [23:16] direction,
    // [31:24] payload_length, [32] checksum_ok, [39:33] zero
    output logic [mspfr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic                           m_axis_tuser,   // [0] kind
    output logic                           m_axis_tlast    // last
);
    import mspfr_pkg::*;

    logic    w_in_valid;
    t_byte   w_in_byte;
    logic    w_out_ready;
    logic    w_consume;
    logic    w_res_valid;
    t_result w_res;
    t_result w_out_res;

    mspfr_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_s_byte  (s_axis_tdata),
        .o_valid   (w_in_valid),
        .o_byte    (w_in_byte),
        .i_ready   (w_out_ready)
    );

    assign w_consume = w_in_valid && w_out_ready;

    mspfr_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_consume),
        .i_byte      (w_in_byte),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    mspfr_out_stage u_out_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_res_valid),
        .o_ready   (w_out_ready),
        .i_res     (w_res),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_m_res   (w_out_res)
    );

    assign m_axis_tdata = {7'b0, w_out_res.checksum_ok, w_out_res.payload_length,
                           w_out_res.direction, w_out_res.message_id,
                           w_out_res.payload_byte};
    assign m_axis_tuser = w_out_res.kind;
    assign m_axis_tlast = w_out_res.last;

`include "msp_v1_frame_receiver_assert.svh"

    `MSPFR_ASSERT_NOW(a_last_is_kind, i_clk, i_rst_n, m_axis_tvalid,
        m_axis_tlast == m_axis_tuser, "tlast and kind disagree")
    `MSPFR_ASSERT_NOW(a_eof_no_data, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser,
        m_axis_tdata[7:0] == 8'h00, "end-of-frame item carries payload")
    `MSPFR_ASSERT_NOW(a_payload_no_ok, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser,
        !m_axis_tdata[32], "payload item carries checksum verdict")
    `MSPFR_ASSERT_NEXT(a_result_lands, i_clk, i_rst_n, w_res_valid,
        m_axis_tvalid, "parsed result not presented")

endmodule

// File: hw/rtl/mspfr_in_stage.sv
module mspfr_in_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_valid,
    output logic                 o_s_ready,
    input  mspfr_pkg::t_byte     i_s_byte,
    output logic                 o_valid,
    output mspfr_pkg::t_byte     o_byte,
    input  logic                 i_ready
);
    import mspfr_pkg::*;

    logic  r_valid;
    logic  n_valid;
    t_byte r_byte;
    logic  w_take;

    assign o_s_ready = !r_valid || i_ready;
    assign w_take    = i_s_valid && o_s_ready;

    always_comb begin
        n_valid = r_valid;
        if (w_take) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_byte <= i_s_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

// File: hw/rtl/mspfr_parser.sv
module mspfr_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  mspfr_pkg::t_byte     i_byte,
    output logic                 o_res_valid,
    output mspfr_pkg::t_result   o_res
);
    import mspfr_pkg::*;

    localparam logic [2:0] PH_HUNT  = 3'd0;
    localparam logic [2:0] PH_MARK  = 3'd1;
    localparam logic [2:0] PH_DIR   = 3'd2;
    localparam logic [2:0] PH_LEN   = 3'd3;
    localparam logic [2:0] PH_ID    = 3'd4;
    localparam logic [2:0] PH_DATA  = 3'd5;
    localparam logic [2:0] PH_CHECK = 3'd6;

    logic [2:0] r_phase, n_phase;
    t_byte      r_dir, n_dir;
    t_byte      r_len, n_len;
    t_byte      r_id, n_id;
    t_byte      r_left, n_left;
    t_byte      r_xor, n_xor;
    logic       w_emit;
    t_result    w_res;

    always_comb begin
        n_phase = r_phase;
        n_dir   = r_dir;
        n_len   = r_len;
        n_id    = r_id;
        n_left  = r_left;
        n_xor   = r_xor;
        w_emit  = 1'b0;
        w_res.kind           = 1'b0;
        w_res.payload_byte   = i_byte;
        w_res.message_id     = r_id;
        w_res.direction      = r_dir;
        w_res.payload_length = r_len;
        w_res.checksum_ok    = 1'b0;
        w_res.last           = 1'b0;
        unique case (r_phase)
            PH_MARK: begin
                // a second start character does not resynchronise
                n_phase = (i_byte == MARK_CHAR) ? PH_DIR : PH_HUNT;
            end
            PH_DIR: begin
                n_dir   = i_byte;
                n_phase = PH_LEN;
            end
            PH_LEN: begin
                n_len   = i_byte;
                n_left  = i_byte;
                n_xor   = i_byte;
                n_phase = PH_ID;
            end
            PH_ID: begin
                n_id    = i_byte;
                n_xor   = r_xor ^ i_byte;
                n_phase = (r_left == '0) ? PH_CHECK : PH_DATA;
            end
            PH_DATA: begin
                n_xor  = r_xor ^ i_byte;
                n_left = r_left - 8'd1;
                if (n_left == '0) begin
                    n_phase = PH_CHECK;
                end
                w_emit = 1'b1;
            end
            PH_CHECK: begin
                w_res.kind         = 1'b1;
                w_res.payload_byte = '0;
                w_res.checksum_ok  = (i_byte == r_xor);
                w_res.last         = 1'b1;
                w_emit  = 1'b1;
                n_phase = PH_HUNT;
            end
            default: begin
                n_phase = (i_byte == START_CHAR) ? PH_MARK : PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_dir   <= '0;
            r_len   <= '0;
            r_id    <= '0;
            r_left  <= '0;
            r_xor   <= '0;
        end else if (i_valid) begin
            r_phase <= n_phase;
            r_dir   <= n_dir;
            r_len   <= n_len;
            r_id    <= n_id;
            r_left  <= n_left;
            r_xor   <= n_xor;
        end
    end

    assign o_res_valid = i_valid && w_emit;
    assign o_res       = w_res;

endmodule

// File: hw/rtl/mspfr_out_stage.sv
module mspfr_out_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  mspfr_pkg::t_result   i_res,
    output logic                 o_m_valid,
    input  logic                 i_m_ready,
    output mspfr_pkg::t_result   o_m_res
);
    import mspfr_pkg::*;

    logic    r_main_valid, n_main_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_main;
    t_result r_skid;
    logic    w_main_free;
    logic    w_load_main;
    logic    w_load_skid;
    logic    w_main_from_skid;

    assign o_ready     = !r_skid_valid;
    assign w_main_free = !r_main_valid || i_m_ready;

    always_comb begin
        n_main_valid     = r_main_valid;
        n_skid_valid     = r_skid_valid;
        w_load_main      = 1'b0;
        w_load_skid      = 1'b0;
        w_main_from_skid = 1'b0;
        if (w_main_free) begin
            if (r_skid_valid) begin
                // drain the skid entry first; no item is taken meanwhile
                w_main_from_skid = 1'b1;
                n_main_valid     = 1'b1;
                n_skid_valid     = 1'b0;
            end else begin
                w_load_main  = i_valid;
                n_main_valid = i_valid;
            end
        end else if (i_valid) begin
            w_load_skid  = 1'b1;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_main_from_skid) begin
            r_main <= r_skid;
        end else if (w_load_main) begin
            r_main <= i_res;
        end
        if (w_load_skid) begin
            r_skid <= i_res;
        end
    end

    assign o_m_valid = r_main_valid;
    assign o_m_res   = r_main;

endmodule
